// File: hw/rtl/gmds_pkg.sv
package gmds_pkg;

  localparam int ROWS_DEF    = 8;
  localparam int COLS_DEF    = 8;
  localparam int STACK_DEPTH = 64;
  localparam int SP_W        = $clog2(STACK_DEPTH);

  // stored cell contents
  typedef enum logic [2:0] {
    CELL_ROAD = 3'd0,
    CELL_WALL = 3'd1,
    CELL_PATH = 3'd2,
    CELL_EXIT = 3'd3,
    CELL_DEAD = 3'd4
  } cell_t;

  // cell_kind codes of a load word
  typedef enum logic [1:0] {
    KIND_ROAD = 2'd0,
    KIND_WALL = 2'd1,
    KIND_EXIT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ST_PATH   = 2'd0,
    ST_NOSOL  = 2'd1,
    ST_ONEXIT = 2'd2
  } status_t;

  typedef enum logic {
    CFG_START_ROW = 1'b0,
    CFG_START_COL = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_SOLVE = 1'b1
  } mode_t;

endpackage

// File: hw/rtl/gmds_grid_mem.sv
// Grid cell store: one write port, one read port, registered read data.
module gmds_grid_mem
  import gmds_pkg::*;
#(
  parameter int DEPTH = ROWS_DEF * COLS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/grid_maze_dfs_solver_core.sv
// Channel   Signals                                         Dir  Word
// input     in_valid/in_ready, mode, cell_row/col, kind     in   load one cell or solve
// result    out_valid/out_ready, direction, last, status    out  one path move or a status
// config    cfg_valid/cfg_ready, cfg_index, cfg_data        in   start_row / start_col
//
// Solve: a sequencer on the single grid read port reads then checks each visited cell
//   and each probed neighbor (no read if out of bounds), marks dead ends and pops moves,
//   then reads each path move from the stack and delivers it, waiting on output stalls.
// Reset: sync, active high. After reset a clearing pass writes road into all ROWS*COLS
//   cells, one per cycle; in_ready stays low until that pass ends. cfg is always ready.
// Stalls: in_ready is high only in idle. The result register holds a word until taken;
//   a new input word is accepted while the last result still waits.
module grid_maze_dfs_solver_core
  import gmds_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input words
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [2:0] cell_row,
  input  logic [2:0] cell_col,
  input  logic [1:0] cell_kind,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] direction,
  output logic       last,
  output logic [1:0] status,
  // configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int CNT_W = SP_W + 1;

  localparam logic [6:0]       ROWS_7   = 7'(ROWS);
  localparam logic [6:0]       COLS_7   = 7'(COLS);
  localparam logic [ROW_W-1:0] ROW_MAX  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_MAX  = COL_W'(COLS - 1);
  localparam logic [AW-1:0]    ADDR_MAX = AW'(CELLS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_RDCUR  = 11'b000_0000_0100, // read cell under cursor
    S_CHKCUR = 11'b000_0000_1000, // exit check
    S_PROBE  = 11'b000_0001_0000, // read neighbor for dir
    S_PCHK   = 11'b000_0010_0000, // neighbor enterable?
    S_DEAD   = 11'b000_0100_0000, // mark dead end, pop
    S_POP    = 11'b000_1000_0000, // step back along popped move
    S_ERD    = 11'b001_0000_0000, // read stacked move
    S_EOUT   = 11'b010_0000_0000, // deliver stacked move
    S_RESULT = 11'b100_0000_0000  // deliver single status word
  } state_t;

  state_t state, state_next;

  // config registers
  logic [2:0] start_row, start_col;

  // walk state
  logic [ROW_W-1:0] cursor_row, cursor_row_next;
  logic [COL_W-1:0] cursor_col, cursor_col_next;
  logic [CNT_W-1:0] stack_count, stack_count_next;
  logic [CNT_W-1:0] emit_k, emit_k_next;
  dir_t             probe_dir, probe_dir_next;
  status_t          res_status, res_status_next;
  logic [AW-1:0]    clr_addr;

  // result register
  logic    out_load;
  dir_t    out_dir_d;
  logic    out_last_d;
  status_t out_status_d;
  logic    out_free;

  // grid port
  logic          g_we, g_re;
  logic [AW-1:0] g_waddr, g_raddr;
  cell_t         g_wdata, g_rdata;

  // move stack
  logic [1:0]      stack_mem [STACK_DEPTH];
  logic            s_we, s_re;
  logic [SP_W-1:0] s_waddr, s_raddr;
  logic [1:0]      s_wdata, s_rdata;

  // neighbor of cursor in probe_dir
  logic [ROW_W-1:0] nb_row;
  logic [COL_W-1:0] nb_col;
  logic             nb_ok;
  logic [AW-1:0]    cur_idx, nb_idx;

  logic in_acc, load_in_grid, start_in_grid;
  cell_t load_cell;

  function automatic logic [AW-1:0] cell_idx(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    cell_idx = AW'(int'(r) * COLS + int'(c));
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  assign load_in_grid  = ({4'd0, cell_row} < ROWS_7) && ({4'd0, cell_col} < COLS_7);
  assign start_in_grid = ({4'd0, start_row} < ROWS_7) && ({4'd0, start_col} < COLS_7);

  always_comb begin
    case (kind_t'(cell_kind))
      KIND_ROAD: load_cell = CELL_ROAD;
      KIND_EXIT: load_cell = CELL_EXIT;
      default:   load_cell = CELL_WALL; // wall and the unused code
    endcase
  end

  always_comb begin
    nb_row = cursor_row;
    nb_col = cursor_col;
    nb_ok  = 1'b0;
    unique case (probe_dir)
      DIR_RIGHT: begin
        nb_col = cursor_col + 1'b1;
        nb_ok  = (cursor_col != COL_MAX);
      end
      DIR_LEFT: begin
        nb_col = cursor_col - 1'b1;
        nb_ok  = (cursor_col != '0);
      end
      DIR_DOWN: begin
        nb_row = cursor_row + 1'b1;
        nb_ok  = (cursor_row != ROW_MAX);
      end
      DIR_UP: begin
        nb_row = cursor_row - 1'b1;
        nb_ok  = (cursor_row != '0);
      end
      default: ;
    endcase
  end

  assign cur_idx = cell_idx(cursor_row, cursor_col);
  assign nb_idx  = cell_idx(nb_row, nb_col);

  // sequencer
  always_comb begin
    state_next       = state;
    cursor_row_next  = cursor_row;
    cursor_col_next  = cursor_col;
    stack_count_next = stack_count;
    emit_k_next      = emit_k;
    probe_dir_next   = probe_dir;
    res_status_next  = res_status;
    g_we    = 1'b0;
    g_waddr = cur_idx;
    g_wdata = CELL_ROAD;
    g_re    = 1'b0;
    g_raddr = cur_idx;
    s_we    = 1'b0;
    s_waddr = stack_count[SP_W-1:0];
    s_wdata = probe_dir;
    s_re    = 1'b0;
    s_raddr = emit_k[SP_W-1:0];
    out_load     = 1'b0;
    out_dir_d    = DIR_RIGHT;
    out_last_d   = 1'b1;
    out_status_d = res_status;

    unique case (state)
      S_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_addr;
        g_wdata = CELL_ROAD;
        if (clr_addr == ADDR_MAX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (mode_t'(mode) == MODE_LOAD) begin
            g_we    = load_in_grid;
            g_waddr = cell_idx(ROW_W'(cell_row), COL_W'(cell_col));
            g_wdata = load_cell;
          end else begin
            stack_count_next = '0;
            if (start_in_grid) begin
              cursor_row_next = ROW_W'(start_row);
              cursor_col_next = COL_W'(start_col);
              state_next      = S_RDCUR;
            end else begin
              res_status_next = ST_NOSOL;
              state_next      = S_RESULT;
            end
          end
        end
      end
      S_RDCUR: begin
        g_re       = 1'b1;
        state_next = S_CHKCUR;
      end
      S_CHKCUR: begin
        if (g_rdata == CELL_EXIT) begin
          if (stack_count == '0) begin
            res_status_next = ST_ONEXIT;
            state_next      = S_RESULT;
          end else begin
            emit_k_next = '0;
            state_next  = S_ERD;
          end
        end else if (stack_count == CNT_FULL) begin
          state_next = S_DEAD; // no room for another move
        end else begin
          probe_dir_next = DIR_RIGHT;
          state_next     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (nb_ok) begin
          g_re       = 1'b1;
          g_raddr    = nb_idx;
          state_next = S_PCHK;
        end else if (probe_dir == DIR_UP) begin
          state_next = S_DEAD;
        end else begin
          probe_dir_next = dir_t'(probe_dir + 2'd1);
        end
      end
      S_PCHK: begin
        if (g_rdata == CELL_ROAD || g_rdata == CELL_EXIT) begin
          g_we             = 1'b1;
          g_wdata          = CELL_PATH;
          s_we             = 1'b1;
          stack_count_next = stack_count + 1'b1;
          cursor_row_next  = nb_row;
          cursor_col_next  = nb_col;
          state_next       = S_RDCUR;
        end else if (probe_dir == DIR_UP) begin
          state_next = S_DEAD;
        end else begin
          probe_dir_next = dir_t'(probe_dir + 2'd1);
          state_next     = S_PROBE;
        end
      end
      S_DEAD: begin
        if (stack_count == '0) begin
          // nothing to back out of; grid left as is
          res_status_next = ST_NOSOL;
          state_next      = S_RESULT;
        end else begin
          g_we             = 1'b1;
          g_wdata          = CELL_DEAD;
          s_re             = 1'b1;
          s_raddr          = SP_W'(stack_count - 1'b1);
          stack_count_next = stack_count - 1'b1;
          state_next       = S_POP;
        end
      end
      S_POP: begin
        unique case (dir_t'(s_rdata))
          DIR_RIGHT: cursor_col_next = cursor_col - 1'b1;
          DIR_LEFT:  cursor_col_next = cursor_col + 1'b1;
          DIR_DOWN:  cursor_row_next = cursor_row - 1'b1;
          DIR_UP:    cursor_row_next = cursor_row + 1'b1;
          default: ;
        endcase
        state_next = S_RDCUR;
      end
      S_ERD: begin
        s_re       = 1'b1;
        state_next = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_dir_d    = dir_t'(s_rdata);
          out_last_d   = (emit_k + 1'b1 == stack_count);
          out_status_d = ST_PATH;
          emit_k_next  = emit_k + 1'b1;
          state_next   = out_last_d ? S_IDLE : S_ERD;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      start_row   <= '0;
      start_col   <= '0;
      cursor_row  <= '0;
      cursor_col  <= '0;
      stack_count <= '0;
      emit_k      <= '0;
      probe_dir   <= DIR_RIGHT;
      res_status  <= ST_PATH;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cursor_row  <= cursor_row_next;
      cursor_col  <= cursor_col_next;
      stack_count <= stack_count_next;
      emit_k      <= emit_k_next;
      probe_dir   <= probe_dir_next;
      res_status  <= res_status_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_START_ROW: start_row <= cfg_data;
          CFG_START_COL: start_col <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (out_load) begin
      direction <= out_dir_d;
      last      <= out_last_d;
      status    <= out_status_d;
    end
  end

  // move stack memory
  always_ff @(posedge clk) begin
    if (s_we) begin
      stack_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata <= stack_mem[s_raddr];
    end
  end

  gmds_grid_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .re    (g_re),
    .raddr (g_raddr),
    .rdata (g_rdata)
  );

endmodule
